FILE: design/u16u8_pkg.sv
package u16u8_pkg;

	localparam int unsigned JOB_DEPTH = 2;

	localparam logic [7:0]  UNIT_LIMIT_RST   = 8'd36;
	localparam logic [10:0] BUFFER_BYTES_RST = 11'd128;

	localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
	localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;
	localparam logic [7:0]  LEAD2        = 8'hC0;
	localparam logic [7:0]  LEAD3        = 8'hE0;
	localparam logic [7:0]  CONT         = 8'h80;

	typedef enum logic [0:0] {
		CFG_UNIT_LIMIT   = 1'b0,
		CFG_BUFFER_BYTES = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        start_string;
	} unit_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [9:0] byte_index;
		logic       is_terminator;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      len;
	} enc_t;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nbytes;
		logic [9:0]      base_idx;
		logic            term;
		logic [9:0]      term_idx;
	} job_t;

	function automatic enc_t encode(input logic [15:0] c);
		enc_t e;
		e = '0;
		if (c < ONE_BYTE_LIM) begin
			e.len      = 2'd1;
			e.bytes[0] = c[7:0];
		end else if (c < TWO_BYTE_LIM) begin
			e.len      = 2'd2;
			e.bytes[0] = LEAD2 | {3'b000, c[10:6]};
			e.bytes[1] = CONT | {2'b00, c[5:0]};
		end else begin
			e.len      = 2'd3;
			e.bytes[0] = LEAD3 | {4'b0000, c[15:12]};
			e.bytes[1] = CONT | {2'b00, c[11:6]};
			e.bytes[2] = CONT | {2'b00, c[5:0]};
		end
		return e;
	endfunction

endpackage

FILE: design/u16u8_front.sv
module u16u8_front #(
	parameter int unsigned MAX_BUFFER_BYTES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  u16u8_pkg::cfg_reg_t cfg_index,
	input  logic [10:0]         cfg_data,
	input  logic                accept,
	input  u16u8_pkg::unit_t    unit,
	output logic                job_v,
	output u16u8_pkg::job_t     job
);
	import u16u8_pkg::*;

	localparam int unsigned BW = $clog2(MAX_BUFFER_BYTES);
	localparam int unsigned CW = ((BW > 11) ? BW : 11) + 2;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_BUFFER_BYTES);

	logic [7:0]    unit_limit_q;
	logic [10:0]   buffer_bytes_q;
	logic [7:0]    units_seen_q;
	logic [BW-1:0] bytes_written_q;
	logic          stopped_q;

	logic [7:0]    us_e, us_n, us_d;
	logic [BW-1:0] bw_e, bw_d;
	logic          stp_e, stp_d;
	logic [CW-1:0] size_c, bw_ext, sum, size_m1;
	enc_t          enc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_limit_q   <= UNIT_LIMIT_RST;
			buffer_bytes_q <= BUFFER_BYTES_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_UNIT_LIMIT) begin
				unit_limit_q <= cfg_data[7:0];
			end else begin
				buffer_bytes_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_seen_q    <= '0;
			bytes_written_q <= '0;
			stopped_q       <= 1'b0;
		end else if (accept) begin
			units_seen_q    <= us_d;
			bytes_written_q <= bw_d;
			stopped_q       <= stp_d;
		end
	end

	always_comb begin
		size_c  = (CW'(buffer_bytes_q) > MAX_C) ? MAX_C : CW'(buffer_bytes_q);
		size_m1 = size_c - CW'(1);
		us_e    = unit.start_string ? '0 : units_seen_q;
		bw_e    = unit.start_string ? '0 : bytes_written_q;
		stp_e   = unit.start_string ? 1'b0 : stopped_q;
		us_n    = us_e + 8'd1;
		enc     = encode(unit.code_unit);
		bw_ext  = CW'(bw_e);
		sum     = bw_ext + CW'(enc.len);
		us_d    = us_e;
		bw_d    = bw_e;
		stp_d   = stp_e;
		job     = '0;
		job_v   = 1'b0;
		if (!stp_e) begin
			if (us_e >= unit_limit_q || unit.code_unit == '0 || sum >= size_c) begin
				stp_d        = 1'b1;
				job_v        = (size_c != '0);
				job.term     = 1'b1;
				job.term_idx = (bw_ext < size_c) ? bw_ext[9:0] : size_m1[9:0];
			end else begin
				job_v        = 1'b1;
				job.bytes    = enc.bytes;
				job.nbytes   = enc.len;
				job.base_idx = bw_ext[9:0];
				bw_d         = sum[BW-1:0];
				us_d         = us_n;
				if (us_n >= unit_limit_q) begin
					stp_d        = 1'b1;
					job.term     = 1'b1;
					job.term_idx = sum[9:0];
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_term_stops: assert property (@(posedge clk) disable iff (!arst_n)
		accept && job_v && job.term |=> stopped_q)
		else $error("terminator queued but string not stopped");
	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stopped_q && !unit.start_string |-> !job_v)
		else $error("stopped string produced a word");
`endif

endmodule

FILE: design/u16u8_fifo.sv
module u16u8_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  u16u8_pkg::job_t wr_job,
	output logic            full,
	input  logic            rd_en,
	output logic            rd_v,
	output u16u8_pkg::job_t rd_job
);
	import u16u8_pkg::*;

	localparam int unsigned PW = $clog2(JOB_DEPTH);

	job_t                      mem_q [JOB_DEPTH];
	logic [PW-1:0]             wr_ptr_q, rd_ptr_q;
	logic [$clog2(JOB_DEPTH+1)-1:0] cnt_q;

	assign full   = (cnt_q == ($clog2(JOB_DEPTH+1))'(JOB_DEPTH));
	assign rd_v   = (cnt_q != '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/u16u8_back.sv
module u16u8_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_v,
	input  u16u8_pkg::job_t    job,
	output logic               job_pop,
	output logic               empty,
	input  logic               pop,
	output u16u8_pkg::result_t result
);
	import u16u8_pkg::*;

	logic [1:0] pos_q;
	logic       valid_q;
	result_t    res_q;
	logic [2:0] total;
	logic       cur_term, last, load;
	logic [7:0] cur_byte;

	always_comb begin
		total    = {1'b0, job.nbytes} + {2'b00, job.term};
		cur_term = (pos_q == job.nbytes);
		last     = ({1'b0, pos_q} + 3'd1 == total);
		load     = job_v && (!valid_q || pop);
		job_pop  = load && last;
		case (pos_q)
			2'd0:    cur_byte = job.bytes[0];
			2'd1:    cur_byte = job.bytes[1];
			2'd2:    cur_byte = job.bytes[2];
			default: cur_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			pos_q   <= last ? 2'd0 : pos_q + 2'd1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte      <= cur_term ? 8'd0 : cur_byte;
			res_q.byte_index    <= cur_term ? job.term_idx : job.base_idx + 10'(pos_q);
			res_q.is_terminator <= cur_term;
			res_q.last_of_run   <= last;
		end
	end

	assign empty  = !valid_q;
	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && pop && !res_q.last_of_run |=> valid_q)
		else $error("run broken before its last word");
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_v && !job.term |-> pos_q < job.nbytes)
		else $error("byte position past end of job");
`endif

endmodule

FILE: design/utf16le_to_utf8_encoder.sv
// UTF-16 code units in, UTF-8 words out, one word per cycle while pop keeps up. The front end
// takes one unit per cycle while its two-entry job queue has room, decides the bytes, index and
// terminator for that unit and updates the string counters; the back end drains one job at a
// time, one word per cycle while words are popped. A unit that is encoded yields 1 to 3 byte
// words, plus a terminator word when it ends the string, and the output word port sets the
// sustained rate. A word passes the job queue and the result register before it shows on
// result. Stopped strings and units that end a string with a zero buffer size give no words.
module utf16le_to_utf8_encoder #(
	parameter int unsigned MAX_BUFFER_BYTES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  u16u8_pkg::cfg_reg_t cfg_index,
	input  logic [10:0]         cfg_data,
	input  logic                push,
	output logic                full,
	input  u16u8_pkg::unit_t    unit,
	output logic                empty,
	input  logic                pop,
	output u16u8_pkg::result_t  result
);
	import u16u8_pkg::*;

	logic accept, job_v, q_v, q_pop;
	job_t job, q_job;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	u16u8_front #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.unit      (unit),
		.job_v     (job_v),
		.job       (job)
	);

	u16u8_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && job_v),
		.wr_job (job),
		.full   (full),
		.rd_en  (q_pop),
		.rd_v   (q_v),
		.rd_job (q_job)
	);

	u16u8_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_v   (q_v),
		.job     (q_job),
		.job_pop (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
